/* rtl/hps_pkg.sv */
// ----------------------------------------------------------------------------
// hps_pkg
// Shared types, codes and the preset pattern table of the haptic sequencer.
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int NUM_PADS_DEF  = 4;
  localparam int MAX_STEPS_DEF = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int MAX_RESULTS   = 4;
  localparam int NUM_PRESETS   = 6;

  localparam int STEP_W = 4;
  localparam int DUR_W  = 10;
  localparam int CNT_W  = 3;

  localparam logic [STEP_W-1:0] STEP_SAT = '1;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_BEGIN = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STOP  = 1'b1;

  localparam logic [2:0] PRESET_SMALL  = 3'd0;
  localparam logic [2:0] PRESET_MEDIUM = 3'd1;
  localparam logic [2:0] PRESET_SOLID  = 3'd2;
  localparam logic [2:0] PRESET_SHOT   = 3'd3;
  localparam logic [2:0] PRESET_SCORE  = 3'd4;
  localparam logic [2:0] PRESET_HYPER  = 3'd5;

  localparam logic [DUR_W-1:0] DUR_SMALL  = 10'h046;
  localparam logic [DUR_W-1:0] DUR_MEDIUM = 10'h0DE;
  localparam logic [DUR_W-1:0] DUR_SOLID  = 10'h1F4;
  localparam logic [DUR_W-1:0] DUR_SHOT   = 10'h14D;
  localparam logic [DUR_W-1:0] DUR_HYPER1 = 10'h0FA;
  localparam logic [DUR_W-1:0] DUR_GAP    = 10'h0C8;
  localparam logic [DUR_W-1:0] DUR_LONG   = 10'h3E7;

  typedef enum logic [1:0] {
    KIND_ON,
    KIND_OFF,
    KIND_END
  } step_kind_e;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_BEGIN,
    OP_STOP
  } op_e;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] pad_index;
    logic [2:0] preset;
    logic [9:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] out_pad;
    logic       command;
    logic [9:0] duration_ms;
    logic       last;
  } out_item_t;

  typedef struct packed {
    op_e        op;
    logic [1:0] pad;
    logic [2:0] preset;
    logic [9:0] elapsed;
  } cmd_t;

  typedef struct packed {
    step_kind_e       kind;
    logic [DUR_W-1:0] dur;
  } step_ent_t;

  localparam step_ent_t END_STEP = '{kind: KIND_END, dur: '0};

  function automatic logic [STEP_W-1:0] sat_inc(logic [STEP_W-1:0] step);
    logic [STEP_W-1:0] r;
    r = (step == STEP_SAT) ? step : step + 1'b1;
    return r;
  endfunction

  function automatic step_ent_t fetch_step(logic [2:0] pat, logic [STEP_W-1:0] step);
    step_ent_t ent;
    ent = END_STEP;
    case (pat)
      PRESET_SMALL:  if (step == '0) ent = '{kind: KIND_ON, dur: DUR_SMALL};
      PRESET_MEDIUM: if (step == '0) ent = '{kind: KIND_ON, dur: DUR_MEDIUM};
      PRESET_SOLID:  if (step == '0) ent = '{kind: KIND_ON, dur: DUR_SOLID};
      PRESET_SHOT:   if (step == '0) ent = '{kind: KIND_ON, dur: DUR_SHOT};
      PRESET_SCORE:  if (step == '0) ent = '{kind: KIND_ON, dur: DUR_SOLID};
      PRESET_HYPER: begin
        case (step)
          4'd0:    ent = '{kind: KIND_ON,  dur: DUR_HYPER1};
          4'd1:    ent = '{kind: KIND_OFF, dur: DUR_GAP};
          4'd2:    ent = '{kind: KIND_ON,  dur: DUR_SOLID};
          4'd3:    ent = '{kind: KIND_OFF, dur: DUR_GAP};
          4'd4:    ent = '{kind: KIND_ON,  dur: DUR_LONG};
          default: ent = END_STEP;
        endcase
      end
      default: ent = END_STEP;
    endcase
    return ent;
  endfunction

endpackage

/* rtl/hps_front.sv */
// ----------------------------------------------------------------------------
// hps_front
// Accepts input beats, drops the ones without effect and queues the rest.
// ----------------------------------------------------------------------------
module hps_front #(
  parameter int NUM_PADS = hps_pkg::NUM_PADS_DEF
) (
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  hps_pkg::in_item_t in_item_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output hps_pkg::cmd_t    q_item_o
);

  logic pad_ok;
  logic keep;

  always_comb begin
    pad_ok = 32'(in_item_i.pad_index) < NUM_PADS;
    keep   = 1'b0;
    q_item_o.op      = hps_pkg::OP_TICK;
    q_item_o.pad     = in_item_i.pad_index;
    q_item_o.preset  = in_item_i.preset;
    q_item_o.elapsed = in_item_i.elapsed_ms;
    case (in_item_i.action)
      hps_pkg::ACT_TICK: begin
        keep = 1'b1;
      end
      hps_pkg::ACT_BEGIN: begin
        q_item_o.op = hps_pkg::OP_BEGIN;
        keep = pad_ok && (32'(in_item_i.preset) < hps_pkg::NUM_PRESETS);
      end
      hps_pkg::ACT_STOP: begin
        q_item_o.op = hps_pkg::OP_STOP;
        keep = pad_ok;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

endmodule

/* rtl/hps_queue.sv */
// ----------------------------------------------------------------------------
// hps_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module hps_queue #(
  parameter int DEPTH = hps_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hps_pkg::cmd_t item_i,
  output logic          full_o,
  output logic          valid_o,
  output hps_pkg::cmd_t item_o,
  input  logic          pop_i
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hps_pkg::cmd_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

/* rtl/hps_back.sv */
// ----------------------------------------------------------------------------
// hps_back
// Pad state and step engine: applies begin and stop, walks the pads on a tick
// one per cycle if not stalled; emits motor commands via an output register.
// ----------------------------------------------------------------------------
module hps_back #(
  parameter int NUM_PADS  = hps_pkg::NUM_PADS_DEF,
  parameter int MAX_STEPS = hps_pkg::MAX_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  hps_pkg::cmd_t      q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hps_pkg::out_item_t out_item_o
);

  localparam int PAD_W  = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
  localparam int STEP_W = hps_pkg::STEP_W;
  localparam int DUR_W  = hps_pkg::DUR_W;
  localparam int CNT_W  = hps_pkg::CNT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_TICK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [PAD_W-1:0]  pad_q, pad_d;
  logic [DUR_W-1:0]  elapsed_q, elapsed_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              pend_valid_q, pend_valid_d;
  hps_pkg::out_item_t pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  hps_pkg::out_item_t out_q, out_d;

  logic [NUM_PADS-1:0] armed_q, armed_d;
  logic [NUM_PADS-1:0] waiting_q, waiting_d;
  logic [STEP_W-1:0]   step_q [NUM_PADS];
  logic [STEP_W-1:0]   step_d [NUM_PADS];
  logic [2:0]          pat_q [NUM_PADS];
  logic [2:0]          pat_d [NUM_PADS];
  logic [DUR_W-1:0]    rem_q [NUM_PADS];
  logic [DUR_W-1:0]    rem_d [NUM_PADS];

  logic              ev_armed, ev_wait, ev_res, ev_cmd, ev_run;
  logic [STEP_W-1:0] ev_step;
  logic [DUR_W-1:0]  ev_rem, ev_dur;
  hps_pkg::step_ent_t ent;

  logic              out_free, push, emit;
  hps_pkg::out_item_t push_item;
  logic [PAD_W-1:0]  cmd_pad;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign cmd_pad     = PAD_W'(q_item_i.pad);

  always_comb begin
    ev_armed = armed_q[pad_q];
    ev_wait  = waiting_q[pad_q];
    ev_step  = step_q[pad_q];
    ev_rem   = rem_q[pad_q];
    ev_res   = 1'b0;
    ev_cmd   = hps_pkg::CMD_STOP;
    ev_dur   = '0;
    ev_run   = 1'b0;
    if (ev_armed) begin
      if (ev_wait && (elapsed_q < ev_rem)) begin
        ev_rem = ev_rem - elapsed_q;
      end else begin
        ev_run = 1'b1;
        if (ev_wait) begin
          ev_rem  = '0;
          ev_wait = 1'b0;
          ev_step = hps_pkg::sat_inc(ev_step);
        end
      end
    end
    ent = hps_pkg::fetch_step(pat_q[pad_q], ev_step);
    if (32'(ev_step) >= MAX_STEPS) begin
      ent = hps_pkg::END_STEP;
    end
    if (ev_run) begin
      case (ent.kind)
        hps_pkg::KIND_ON: begin
          if (ent.dur != '0) begin
            ev_rem  = ent.dur;
            ev_wait = 1'b1;
            ev_res  = 1'b1;
            ev_cmd  = hps_pkg::CMD_START;
            ev_dur  = ent.dur;
          end else begin
            ev_step = hps_pkg::sat_inc(ev_step);
          end
        end
        hps_pkg::KIND_OFF: begin
          ev_res = 1'b1;
          if (ent.dur != '0) begin
            ev_rem  = ent.dur;
            ev_wait = 1'b1;
          end else begin
            ev_step = hps_pkg::sat_inc(ev_step);
          end
        end
        default: begin
          ev_res   = 1'b1;
          ev_armed = 1'b0;
          ev_wait  = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    pad_d        = pad_q;
    elapsed_d    = elapsed_q;
    cnt_d        = cnt_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    armed_d      = armed_q;
    waiting_d    = waiting_q;
    step_d       = step_q;
    pat_d        = pat_q;
    rem_d        = rem_q;
    q_pop_o      = 1'b0;
    push         = 1'b0;
    push_item    = pend_q;
    emit         = ev_res && (cnt_q < CNT_W'(hps_pkg::MAX_RESULTS));

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_item_i.op)
            hps_pkg::OP_BEGIN: begin
              armed_d[cmd_pad]   = 1'b1;
              waiting_d[cmd_pad] = 1'b0;
              step_d[cmd_pad]    = '0;
              pat_d[cmd_pad]     = q_item_i.preset;
              q_pop_o            = 1'b1;
            end
            hps_pkg::OP_STOP: begin
              if (out_free) begin
                armed_d[cmd_pad]      = 1'b0;
                waiting_d[cmd_pad]    = 1'b0;
                step_d[cmd_pad]       = '0;
                push                  = 1'b1;
                push_item.out_pad     = q_item_i.pad;
                push_item.command     = hps_pkg::CMD_STOP;
                push_item.duration_ms = '0;
                push_item.last        = 1'b1;
                q_pop_o               = 1'b1;
              end
            end
            hps_pkg::OP_TICK: begin
              elapsed_d = q_item_i.elapsed;
              pad_d     = '0;
              cnt_d     = '0;
              state_d   = ST_TICK;
              q_pop_o   = 1'b1;
            end
            default: q_pop_o = 1'b1;
          endcase
        end
      end
      ST_TICK: begin
        if (!emit || !pend_valid_q || out_free) begin
          armed_d[pad_q]   = ev_armed;
          waiting_d[pad_q] = ev_wait;
          step_d[pad_q]    = ev_step;
          rem_d[pad_q]     = ev_rem;
          if (emit) begin
            if (pend_valid_q) begin
              push           = 1'b1;
              push_item.last = 1'b0;
            end
            pend_valid_d       = 1'b1;
            pend_d.out_pad     = 2'(pad_q);
            pend_d.command     = ev_cmd;
            pend_d.duration_ms = ev_dur;
            pend_d.last        = 1'b0;
            cnt_d              = cnt_q + 1'b1;
          end
          if (pad_q == PAD_W'(NUM_PADS - 1)) begin
            state_d = ST_FLUSH;
          end else begin
            pad_d = pad_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          push           = 1'b1;
          push_item.last = 1'b1;
          pend_valid_d   = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_d       = push_item;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pad_q        <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      armed_q      <= '0;
      waiting_q    <= '0;
      for (int i = 0; i < NUM_PADS; i++) begin
        step_q[i] <= '0;
        pat_q[i]  <= '0;
        rem_q[i]  <= '0;
      end
    end else begin
      state_q      <= state_d;
      pad_q        <= pad_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      armed_q      <= armed_d;
      waiting_q    <= waiting_d;
      step_q       <= step_d;
      pat_q        <= pat_d;
      rem_q        <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elapsed_q <= elapsed_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
  end

endmodule

/* rtl/haptic_pattern_sequencer.sv */
// ----------------------------------------------------------------------------
// haptic_pattern_sequencer
// Multi-channel vibration pattern player with preset patterns in ROM.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_item_i): tick, begin and stop
// beats. Beats that have no effect (bad pad, bad preset, unknown action) are
// accepted and dropped. A two-entry queue decouples input from the engine.
// Output channel (out_valid_o / out_stall_i / out_item_o): motor commands,
// with last set on the final command caused by one input beat. A tick gives
// zero to four commands, a stop exactly one, a begin none.
// Timing: a beat enters the queue the cycle it is accepted. Begin and stop are
// applied in the idle state as they are popped, a stop once the output
// register is free. A tick runs in steps: load, the pads one at a time through
// the single pad-state read path, release of the final command. A tick holds
// each command until the next one is made or the final step, so last can be
// marked; a released command appears the cycle after, in the output register.
// A stalled output holds its beat; the engine waits until the output register
// frees, and the input stalls once the queue is full.
// Reset clears every pad to disarmed at step 0 and empties queue and output.
// ----------------------------------------------------------------------------
module haptic_pattern_sequencer #(
  parameter int NUM_PADS  = hps_pkg::NUM_PADS_DEF,
  parameter int MAX_STEPS = hps_pkg::MAX_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hps_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hps_pkg::out_item_t out_item_o
);

  logic          q_full, q_push, q_valid, q_pop;
  hps_pkg::cmd_t q_in, q_out;

  hps_front #(
    .NUM_PADS (NUM_PADS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in)
  );

  hps_queue #(
    .DEPTH (hps_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_out),
    .pop_i   (q_pop)
  );

  hps_back #(
    .NUM_PADS  (NUM_PADS),
    .MAX_STEPS (MAX_STEPS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* rtl/hps_checker.sv */
// ----------------------------------------------------------------------------
// hps_checker
// Port-level checks of the haptic sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module hps_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input hps_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input hps_pkg::out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output beat changed");

  a_start_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.command == hps_pkg::CMD_START) |->
      (out_item_o.duration_ms != '0) && (out_item_o.duration_ms <= 10'd999))
    else $error("start command without valid duration");

  a_stop_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.command == hps_pkg::CMD_STOP) |->
      (out_item_o.duration_ms == '0))
    else $error("stop command with nonzero duration");

  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("stalled input beat changed");

endmodule

bind haptic_pattern_sequencer hps_checker u_hps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

/* sim/hps_command_checker.sv */
// ----------------------------------------------------------------------------
// hps_command_checker
// Watches both channels of the haptic sequencer. Every accepted input beat
// is run through a per-pad pattern player kept here, which queues the motor
// commands that beat should cause. Every accepted output beat is compared
// field by field with the oldest queued command. The error count and the
// number of commands still owed go up to the testbench top.
// ----------------------------------------------------------------------------
module hps_command_checker #(
  parameter int NUM_PADS  = hps_pkg::NUM_PADS_DEF,
  parameter int MAX_STEPS = hps_pkg::MAX_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  hps_pkg::in_item_t  in_item_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  hps_pkg::out_item_t out_item_i,
  output int                 err_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic                       pad_armed   [NUM_PADS];
  logic                       pad_waiting [NUM_PADS];
  logic [hps_pkg::STEP_W-1:0] pad_step    [NUM_PADS];
  logic [2:0]                 pad_pattern [NUM_PADS];
  logic [10:0]                pad_left    [NUM_PADS];

  hps_pkg::out_item_t motor_cmds_q[$];

  initial err_count_o = 0;

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("%0t hps_command_checker: %s got %0d want %0d", $time, what, got, want);
    err_count_o++;
  endtask

  task automatic bump_step(input int p);
    if (pad_step[p] != hps_pkg::STEP_SAT) pad_step[p] = pad_step[p] + 1'b1;
  endtask

  task automatic predict_commands(input hps_pkg::in_item_t beat);
    hps_pkg::out_item_t        burst[$];
    hps_pkg::step_kind_e       kind;
    logic [hps_pkg::DUR_W-1:0] dur;
    logic                      run;
    int                        p;
    case (beat.action)
      hps_pkg::ACT_BEGIN: begin
        if (beat.pad_index < NUM_PADS && beat.preset < hps_pkg::NUM_PRESETS) begin
          pad_armed[beat.pad_index]   = 1'b1;
          pad_waiting[beat.pad_index] = 1'b0;
          pad_step[beat.pad_index]    = '0;
          pad_pattern[beat.pad_index] = beat.preset;
        end
      end
      hps_pkg::ACT_STOP: begin
        if (beat.pad_index < NUM_PADS) begin
          pad_armed[beat.pad_index]   = 1'b0;
          pad_waiting[beat.pad_index] = 1'b0;
          pad_step[beat.pad_index]    = '0;
          burst.push_back('{out_pad: beat.pad_index, command: hps_pkg::CMD_STOP,
                            duration_ms: '0, last: 1'b0});
        end
      end
      hps_pkg::ACT_TICK: begin
        for (p = 0; p < NUM_PADS; p++) begin
          if (pad_armed[p]) begin
            run = 1'b1;
            if (pad_waiting[p]) begin
              if (beat.elapsed_ms < pad_left[p]) begin
                pad_left[p] = pad_left[p] - beat.elapsed_ms;
                run = 1'b0;
              end else begin
                pad_left[p]    = '0;
                pad_waiting[p] = 1'b0;
                bump_step(p);
              end
            end
            if (run) begin
              kind = hps_pkg::KIND_END;
              dur  = '0;
              if (pad_pattern[p] < hps_pkg::NUM_PRESETS && pad_step[p] < MAX_STEPS) begin
                if (pad_step[p] == '0) begin
                  kind = hps_pkg::KIND_ON;
                  case (pad_pattern[p])
                    hps_pkg::PRESET_SMALL:  dur = hps_pkg::DUR_SMALL;
                    hps_pkg::PRESET_MEDIUM: dur = hps_pkg::DUR_MEDIUM;
                    hps_pkg::PRESET_SOLID,
                    hps_pkg::PRESET_SCORE:  dur = hps_pkg::DUR_SOLID;
                    hps_pkg::PRESET_SHOT:   dur = hps_pkg::DUR_SHOT;
                    default:                dur = hps_pkg::DUR_HYPER1;
                  endcase
                end else if (pad_pattern[p] == hps_pkg::PRESET_HYPER) begin
                  case (pad_step[p])
                    4'd1, 4'd3: begin
                      kind = hps_pkg::KIND_OFF;
                      dur  = hps_pkg::DUR_GAP;
                    end
                    4'd2: begin
                      kind = hps_pkg::KIND_ON;
                      dur  = hps_pkg::DUR_SOLID;
                    end
                    4'd4: begin
                      kind = hps_pkg::KIND_ON;
                      dur  = hps_pkg::DUR_LONG;
                    end
                    default: ;
                  endcase
                end
              end
              case (kind)
                hps_pkg::KIND_ON: begin
                  if (dur != '0) begin
                    pad_left[p]    = 11'(dur);
                    pad_waiting[p] = 1'b1;
                    if (burst.size() < hps_pkg::MAX_RESULTS)
                      burst.push_back('{out_pad: 2'(p), command: hps_pkg::CMD_START,
                                        duration_ms: dur, last: 1'b0});
                  end else begin
                    bump_step(p);
                  end
                end
                hps_pkg::KIND_OFF: begin
                  if (burst.size() < hps_pkg::MAX_RESULTS)
                    burst.push_back('{out_pad: 2'(p), command: hps_pkg::CMD_STOP,
                                      duration_ms: '0, last: 1'b0});
                  if (dur != '0) begin
                    pad_left[p]    = 11'(dur);
                    pad_waiting[p] = 1'b1;
                  end else begin
                    bump_step(p);
                  end
                end
                default: begin
                  if (burst.size() < hps_pkg::MAX_RESULTS)
                    burst.push_back('{out_pad: 2'(p), command: hps_pkg::CMD_STOP,
                                      duration_ms: '0, last: 1'b0});
                  pad_armed[p]   = 1'b0;
                  pad_waiting[p] = 1'b0;
                end
              endcase
            end
          end
        end
      end
      default: ;
    endcase
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[i]) motor_cmds_q.push_back(burst[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hps_pkg::out_item_t want;
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PADS; p++) begin
        pad_armed[p]   = 1'b0;
        pad_waiting[p] = 1'b0;
        pad_step[p]    = '0;
        pad_pattern[p] = '0;
        pad_left[p]    = '0;
      end
      motor_cmds_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) predict_commands(in_item_i);
      if (out_valid_i && !out_stall_i) begin
        if (motor_cmds_q.size() == 0) begin
          report("command with none pending, pad", out_item_i.out_pad, 0);
        end else begin
          want = motor_cmds_q.pop_front();
          if (out_item_i.out_pad != want.out_pad)
            report("out_pad", out_item_i.out_pad, want.out_pad);
          if (out_item_i.command != want.command)
            report("command", out_item_i.command, want.command);
          if (out_item_i.duration_ms != want.duration_ms)
            report("duration_ms", out_item_i.duration_ms, want.duration_ms);
          if (out_item_i.last != want.last)
            report("last", out_item_i.last, want.last);
        end
      end
    end
    pending_o = motor_cmds_q.size();
  end

endmodule

/* sim/haptic_pattern_sequencer_tb.sv */
// ----------------------------------------------------------------------------
// haptic_pattern_sequencer_tb
// Drives begin, stop and tick beats into the sequencer: a directed opening
// that walks every preset, timer expiry on the exact boundary, a restart of
// a running wait and a four-command tick, then a long random mix with noise
// beats. Both channels idle at random and the receiver holds off once for a
// long stretch. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module haptic_pattern_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  ACT_SPARE    = 2'd3;
  localparam int unsigned RANDOM_BEATS = 280;
  localparam int unsigned HOLD_AT      = 120;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  hps_pkg::in_item_t  in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  hps_pkg::out_item_t out_item_o;

  int          err_count;
  int          pending;
  logic        hold_go;
  int unsigned cycle_count;

  haptic_pattern_sequencer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  hps_command_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  initial cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("haptic_pattern_sequencer_tb: done, errors");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  function automatic hps_pkg::in_item_t make_beat(logic [1:0] act, logic [1:0] pad,
                                                  logic [2:0] pre, logic [9:0] ms);
    return '{action: act, pad_index: pad, preset: pre, elapsed_ms: ms};
  endfunction

  // enter and leave at a falling edge
  task automatic send_beat(input hps_pkg::in_item_t beat, input int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned run_left;
    int unsigned hold_left;
    bit          run_stall;
    bit          hold_done;
    run_left    = 0;
    hold_left   = 0;
    run_stall   = 1'b1;
    hold_done   = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_stall = !run_stall;
          if (run_stall) run_left = idle_len() + 1;
          else if ($urandom_range(0, 99) < 70) run_left = $urandom_range(1, 8);
          else run_left = $urandom_range(40, 150);
        end
        run_left--;
        out_stall_i <= run_stall;
      end
    end
  end

  initial begin
    int unsigned useful;
    int unsigned sent;
    int unsigned r;
    int unsigned gap;
    bit          calm;
    logic [9:0]  ms;
    logic [2:0]  pre;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    hold_go    = 1'b0;
    rst_ni     = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_beat(make_beat(hps_pkg::ACT_STOP, 2'd0, hps_pkg::PRESET_SMALL, 10'd0), idle_len());
    send_beat(make_beat(hps_pkg::ACT_TICK, 2'd0, hps_pkg::PRESET_SMALL, 10'd0), idle_len());
    send_beat(make_beat(hps_pkg::ACT_BEGIN, 2'd0, hps_pkg::PRESET_SMALL, 10'd0), idle_len());
    send_beat(make_beat(hps_pkg::ACT_BEGIN, 2'd1, hps_pkg::PRESET_HYPER, 10'd0), idle_len());
    send_beat(make_beat(hps_pkg::ACT_BEGIN, 2'd2, 3'd6, 10'd0), idle_len());
    send_beat(make_beat(ACT_SPARE, 2'd3, 3'd7, 10'd1023), idle_len());
    send_beat(make_beat(hps_pkg::ACT_TICK, 2'd0, hps_pkg::PRESET_SMALL, 10'd0), idle_len());
    send_beat(make_beat(hps_pkg::ACT_TICK, 2'd0, hps_pkg::PRESET_SMALL, 10'd69), idle_len());
    send_beat(make_beat(hps_pkg::ACT_TICK, 2'd0, hps_pkg::PRESET_SMALL, 10'd1), idle_len());
    send_beat(make_beat(hps_pkg::ACT_BEGIN, 2'd2, hps_pkg::PRESET_SOLID, 10'd0), idle_len());
    send_beat(make_beat(hps_pkg::ACT_BEGIN, 2'd3, hps_pkg::PRESET_SHOT, 10'd0), idle_len());
    send_beat(make_beat(hps_pkg::ACT_BEGIN, 2'd0, hps_pkg::PRESET_MEDIUM, 10'd0), idle_len());
    send_beat(make_beat(hps_pkg::ACT_TICK, 2'd3, 3'd7, 10'd1023), idle_len());
    send_beat(make_beat(hps_pkg::ACT_BEGIN, 2'd3, hps_pkg::PRESET_SCORE, 10'd0), idle_len());
    send_beat(make_beat(hps_pkg::ACT_TICK, 2'd0, hps_pkg::PRESET_SMALL, 10'd200), idle_len());
    send_beat(make_beat(hps_pkg::ACT_STOP, 2'd2, hps_pkg::PRESET_SMALL, 10'd0), idle_len());
    send_beat(make_beat(hps_pkg::ACT_TICK, 2'd0, hps_pkg::PRESET_SMALL, 10'd1023), idle_len());
    send_beat(make_beat(hps_pkg::ACT_TICK, 2'd0, hps_pkg::PRESET_SMALL, 10'd1023), idle_len());
    send_beat(make_beat(hps_pkg::ACT_TICK, 2'd0, hps_pkg::PRESET_SMALL, 10'd1023), idle_len());
    send_beat(make_beat(hps_pkg::ACT_BEGIN, 2'd3, 3'd7, 10'd0), idle_len());
    send_beat(make_beat(hps_pkg::ACT_TICK, 2'd0, hps_pkg::PRESET_SMALL, 10'd5), idle_len());
    send_beat(make_beat(hps_pkg::ACT_STOP, 2'd3, hps_pkg::PRESET_SMALL, 10'd0), idle_len());

    useful = 0;
    sent   = 0;
    while (useful < RANDOM_BEATS) begin
      if (useful == HOLD_AT) hold_go <= 1'b1;
      calm = ((sent / 40) % 4 == 3) || (useful >= HOLD_AT && useful < HOLD_AT + 40);
      gap  = calm ? 0 : idle_len();
      r    = $urandom_range(0, 99);
      sent++;
      if (r < 55) begin
        case ($urandom_range(0, 2))
          0:       ms = 10'($urandom_range(0, 80));
          1:       ms = 10'($urandom_range(0, 400));
          default: ms = 10'($urandom_range(0, 1023));
        endcase
        send_beat(make_beat(hps_pkg::ACT_TICK, 2'($urandom), 3'($urandom), ms), gap);
        useful++;
      end else if (r < 80) begin
        pre = ($urandom_range(0, 2) == 0) ? hps_pkg::PRESET_HYPER : 3'($urandom_range(0, 5));
        send_beat(make_beat(hps_pkg::ACT_BEGIN, 2'($urandom), pre, 10'($urandom)), gap);
        useful++;
      end else if (r < 92) begin
        send_beat(make_beat(hps_pkg::ACT_STOP, 2'($urandom), 3'($urandom), 10'($urandom)),
                  gap);
        useful++;
      end else if (r < 96) begin
        send_beat(make_beat(hps_pkg::ACT_BEGIN, 2'($urandom), 3'($urandom_range(6, 7)),
                            10'($urandom)), gap);
      end else begin
        send_beat(make_beat(ACT_SPARE, 2'($urandom), 3'($urandom), 10'($urandom)), gap);
      end
    end
    in_valid_i <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("haptic_pattern_sequencer_tb: done, clean");
    end else begin
      $display("haptic_pattern_sequencer_tb: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/hps_pkg.sv
rtl/hps_front.sv
rtl/hps_queue.sv
rtl/hps_back.sv
rtl/haptic_pattern_sequencer.sv
rtl/hps_checker.sv
sim/hps_command_checker.sv
sim/haptic_pattern_sequencer_tb.sv
